[design/iol_pkg.sv]
// Shared types and constants for the indexed ordered list.
// Used by iol_cell and indexed_ordered_list_core; no dependencies.
package iol_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 4;
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int DATA_W = 64;
  localparam int KIND_W = 4;
  localparam int SIZE_W = 8;
  localparam int EB_W   = 4;
  localparam int STAT_W = 3;

  localparam logic [KIND_W-1:0] KIND_PUSH      = 4'd0;
  localparam logic [KIND_W-1:0] KIND_POP       = 4'd1;
  localparam logic [KIND_W-1:0] KIND_FRONT     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_BACK      = 4'd3;
  localparam logic [KIND_W-1:0] KIND_READ_AT   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_INSERT    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_ERASE     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_OVERWRITE = 4'd7;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_SIZE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic             write;
    logic             shift_back;
    logic             shift_fwd;
    logic [IDX_W-1:0] wpos;
    logic [IDX_W-1:0] spos;
    logic [IDX_W-1:0] rpos;
  } cell_ctl_t;

endpackage

[design/iol_cell.sv]
// One storage cell of the ordered list chain.
// Depends on iol_pkg for the control struct and widths.
module iol_cell (
  input  logic                      clk,
  input  iol_pkg::cell_ctl_t        ctl,
  input  logic [iol_pkg::IDX_W-1:0] cell_index,
  input  logic [iol_pkg::DATA_W-1:0] wr_data,
  input  logic [iol_pkg::DATA_W-1:0] prev_value,
  input  logic [iol_pkg::DATA_W-1:0] next_value,
  output logic [iol_pkg::DATA_W-1:0] value,
  output logic [iol_pkg::DATA_W-1:0] read_term
);

  logic [iol_pkg::DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    if (ctl.write && (cell_index == ctl.wpos)) begin
      value_next = wr_data;
    end else if (ctl.shift_back && (cell_index > ctl.spos)) begin
      value_next = prev_value;
    end else if (ctl.shift_fwd && (cell_index >= ctl.spos)) begin
      value_next = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign read_term = (cell_index == ctl.rpos) ? value : '0;

endmodule

[design/indexed_ordered_list_core.sv]
// Top level of the indexed ordered list: command decode, count, output register.
// Depends on iol_pkg and a row of iol_cell instances.
//
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tuser kind, s_tdata position/data/size
// m       | out | m_tvalid/m_tready  | m_tdata status/read_value/count/is_empty
// cfg     | in  | cfg_valid/cfg_ready| cfg_data element_bytes
//
// All cells shift, load or hold in parallel at the accepting edge, and the
// result lands in the output register at that edge. Sustained rate is one item
// per cycle when m_tready is high; the output register is the only stage.
// Reset clears the count, the output valid and sets element_bytes to 4.
// While a result waits on m_tready, a new item is taken only as it leaves.
module indexed_ordered_list_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] position, [67:4] data_value, [75:68] size_given, [79:76] zero
  input  logic [79:0] s_tdata,
  // [3:0] kind
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] status, [66:3] read_value, [71:67] element_count, [72] is_empty,
  // [79:73] zero
  output logic [79:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int DEPTH  = iol_pkg::DEPTH;
  localparam int IDX_W  = iol_pkg::IDX_W;
  localparam int CNT_W  = iol_pkg::CNT_W;
  localparam int CMP_W  = iol_pkg::CMP_W;
  localparam int DATA_W = iol_pkg::DATA_W;

  logic [iol_pkg::EB_W-1:0]   element_bytes;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;

  logic [iol_pkg::KIND_W-1:0] kind;
  logic [iol_pkg::POS_W-1:0]  position;
  logic [DATA_W-1:0]          data_value;
  logic [iol_pkg::SIZE_W-1:0] size_given;

  logic                       accept;
  logic                       empty;
  logic                       full;
  logic                       exact;
  logic                       enough;
  logic                       out_range;
  logic                       do_read;
  logic [CMP_W-1:0]           pos_x;
  logic [CMP_W-1:0]           cnt_x;
  logic [DATA_W-1:0]          mask;
  logic [DATA_W-1:0]          read_bus;
  logic [iol_pkg::STAT_W-1:0] status;
  iol_pkg::cell_ctl_t         ctl_raw;
  iol_pkg::cell_ctl_t         ctl;

  logic [DATA_W-1:0]          cell_value [DEPTH];
  logic [DATA_W-1:0]          cell_read  [DEPTH];

  logic [iol_pkg::STAT_W-1:0] out_status;
  logic [DATA_W-1:0]          out_value;
  logic [CNT_W-1:0]           out_count;
  logic                       out_empty;

  assign kind       = s_tuser;
  assign position   = s_tdata[3:0];
  assign data_value = s_tdata[67:4];
  assign size_given = s_tdata[75:68];

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign empty     = (count == '0);
  assign full      = (count >= CNT_W'(DEPTH));
  assign exact     = (size_given == {{(iol_pkg::SIZE_W - iol_pkg::EB_W){1'b0}}, element_bytes});
  assign enough    = (size_given >= {{(iol_pkg::SIZE_W - iol_pkg::EB_W){1'b0}}, element_bytes});
  assign pos_x     = CMP_W'(position);
  assign cnt_x     = CMP_W'(count);
  assign out_range = (pos_x >= cnt_x) || (pos_x >= CMP_W'(DEPTH));

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[8*k +: 8] = (element_bytes > 4'(k)) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    status             = iol_pkg::ST_OK;
    do_read            = 1'b0;
    count_next         = count;
    ctl_raw            = '0;
    case (kind)
      iol_pkg::KIND_PUSH: begin
        if (!exact) status = iol_pkg::ST_SIZE;
        else if (full) status = iol_pkg::ST_FULL;
        else begin
          ctl_raw.write = 1'b1;
          ctl_raw.wpos  = count[IDX_W-1:0];
          count_next    = count + 1'b1;
        end
      end
      iol_pkg::KIND_POP: begin
        if (empty) status = iol_pkg::ST_EMPTY;
        else begin
          ctl_raw.shift_fwd = 1'b1;
          count_next        = count - 1'b1;
        end
      end
      iol_pkg::KIND_FRONT: begin
        if (!exact) status = iol_pkg::ST_SIZE;
        else if (empty) status = iol_pkg::ST_EMPTY;
        else do_read = 1'b1;
      end
      iol_pkg::KIND_BACK: begin
        if (empty) status = iol_pkg::ST_EMPTY;
        else if (!exact) status = iol_pkg::ST_SIZE;
        else begin
          do_read      = 1'b1;
          ctl_raw.rpos = IDX_W'(count - 1'b1);
        end
      end
      iol_pkg::KIND_READ_AT: begin
        if (!enough) status = iol_pkg::ST_SIZE;
        else if (out_range) status = iol_pkg::ST_RANGE;
        else begin
          do_read      = 1'b1;
          ctl_raw.rpos = IDX_W'(position);
        end
      end
      iol_pkg::KIND_INSERT: begin
        if (empty) status = iol_pkg::ST_EMPTY;
        else if (!exact) status = iol_pkg::ST_SIZE;
        else if (out_range) status = iol_pkg::ST_RANGE;
        else if (full) status = iol_pkg::ST_FULL;
        else begin
          ctl_raw.write      = 1'b1;
          ctl_raw.shift_back = 1'b1;
          ctl_raw.wpos       = IDX_W'(position);
          ctl_raw.spos       = IDX_W'(position);
          count_next         = count + 1'b1;
        end
      end
      iol_pkg::KIND_ERASE: begin
        if (empty) status = iol_pkg::ST_EMPTY;
        else if (out_range) status = iol_pkg::ST_RANGE;
        else begin
          ctl_raw.shift_fwd = 1'b1;
          ctl_raw.spos      = IDX_W'(position);
          count_next        = count - 1'b1;
        end
      end
      iol_pkg::KIND_OVERWRITE: begin
        if (empty) status = iol_pkg::ST_EMPTY;
        else if (!enough) status = iol_pkg::ST_SIZE;
        else if (out_range) status = iol_pkg::ST_RANGE;
        else begin
          ctl_raw.write = 1'b1;
          ctl_raw.wpos  = IDX_W'(position);
        end
      end
      iol_pkg::KIND_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl = ctl_raw;
    if (!accept) begin
      ctl.write      = 1'b0;
      ctl.shift_back = 1'b0;
      ctl.shift_fwd  = 1'b0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_v;
    logic [DATA_W-1:0] next_v;
    if (i == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_prev
      assign prev_v = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_v = cell_value[i];
    end else begin : g_next
      assign next_v = cell_value[i+1];
    end
    iol_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_index (IDX_W'(i)),
      .wr_data    (data_value & mask),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_value[i]),
      .read_term  (cell_read[i])
    );
  end

  always_comb begin
    read_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_bus = read_bus | cell_read[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= 4'd4;
      count         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        element_bytes <= cfg_data;
      end
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status;
      out_value  <= do_read ? (read_bus & mask) : '0;
      out_count  <= count_next;
      out_empty  <= (count_next == '0);
    end
  end

  assign m_tdata = {7'd0, out_empty, out_count, out_value, out_status};

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for indexed_ordered_list_core: a queue-fed driver, a
// result monitor and an item-level predictor of the list and its element size.
// Depends on iol_pkg and the RTL of indexed_ordered_list_core.
module testbench;

  typedef struct packed {
    logic [iol_pkg::KIND_W-1:0] kind;
    logic [iol_pkg::POS_W-1:0]  position;
    logic [iol_pkg::DATA_W-1:0] data_value;
    logic [iol_pkg::SIZE_W-1:0] size_given;
  } list_op_t;

  typedef struct packed {
    logic [iol_pkg::STAT_W-1:0] status;
    logic [iol_pkg::DATA_W-1:0] read_value;
    logic [iol_pkg::CNT_W-1:0]  element_count;
    logic                       is_empty;
  } list_reply_t;

  localparam logic [iol_pkg::KIND_W-1:0] KIND_KIND_UNUSED_LOW = iol_pkg::KIND_CLEAR + 4'd1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  list_op_t    list_ops_q[$];
  list_reply_t expected_replies[$];
  list_op_t    offered;

  logic [iol_pkg::DATA_W-1:0] list_cells[iol_pkg::DEPTH];
  int                         list_len = 0;
  logic [iol_pkg::EB_W-1:0]   cfg_bytes = 4'd4;

  int mismatch_count = 0;
  int replies_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit long_hold_done = 1'b0;
  bit idling_on = 1'b1;

  indexed_ordered_list_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic list_reply_t apply_list_op(list_op_t op);
    list_reply_t                r;
    logic [iol_pkg::DATA_W-1:0] mask;
    logic                       exact;
    logic                       enough;
    int                         p;
    if (cfg_bytes >= 8) mask = '1;
    else if (cfg_bytes == 0) mask = '0;
    else mask = (64'd1 << (8 * cfg_bytes)) - 64'd1;
    exact = (op.size_given == {4'd0, cfg_bytes});
    enough = (op.size_given >= {4'd0, cfg_bytes});
    p = int'(op.position);
    r = '0;
    r.status = iol_pkg::ST_OK;
    case (op.kind)
      iol_pkg::KIND_PUSH: begin
        if (!exact) r.status = iol_pkg::ST_SIZE;
        else if (list_len >= iol_pkg::DEPTH) r.status = iol_pkg::ST_FULL;
        else begin
          list_cells[list_len] = op.data_value & mask;
          list_len++;
        end
      end
      iol_pkg::KIND_POP: begin
        if (list_len == 0) r.status = iol_pkg::ST_EMPTY;
        else begin
          for (int i = 0; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
          list_len--;
        end
      end
      iol_pkg::KIND_FRONT: begin
        if (!exact) r.status = iol_pkg::ST_SIZE;
        else if (list_len == 0) r.status = iol_pkg::ST_EMPTY;
        else r.read_value = list_cells[0] & mask;
      end
      iol_pkg::KIND_BACK: begin
        if (list_len == 0) r.status = iol_pkg::ST_EMPTY;
        else if (!exact) r.status = iol_pkg::ST_SIZE;
        else r.read_value = list_cells[list_len - 1] & mask;
      end
      iol_pkg::KIND_READ_AT: begin
        if (!enough) r.status = iol_pkg::ST_SIZE;
        else if (p >= list_len) r.status = iol_pkg::ST_RANGE;
        else r.read_value = list_cells[p] & mask;
      end
      iol_pkg::KIND_INSERT: begin
        if (list_len == 0) r.status = iol_pkg::ST_EMPTY;
        else if (!exact) r.status = iol_pkg::ST_SIZE;
        else if (p >= list_len) r.status = iol_pkg::ST_RANGE;
        else if (list_len >= iol_pkg::DEPTH) r.status = iol_pkg::ST_FULL;
        else begin
          for (int i = list_len; i > p; i--) list_cells[i] = list_cells[i - 1];
          list_cells[p] = op.data_value & mask;
          list_len++;
        end
      end
      iol_pkg::KIND_ERASE: begin
        if (list_len == 0) r.status = iol_pkg::ST_EMPTY;
        else if (p >= list_len) r.status = iol_pkg::ST_RANGE;
        else begin
          for (int i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
          list_len--;
        end
      end
      iol_pkg::KIND_OVERWRITE: begin
        if (list_len == 0) r.status = iol_pkg::ST_EMPTY;
        else if (!enough) r.status = iol_pkg::ST_SIZE;
        else if (p >= list_len) r.status = iol_pkg::ST_RANGE;
        else list_cells[p] = op.data_value & mask;
      end
      iol_pkg::KIND_CLEAR: list_len = 0;
      default: ;
    endcase
    r.element_count = 5'(list_len);
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) expected_replies.push_back(apply_list_op(offered));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (list_ops_q.size() > 0) begin
          offered = list_ops_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= offered.kind;
          s_tdata <= {4'b0, offered.size_given, offered.data_value, offered.position};
          if (idling_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 7);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    list_reply_t got;
    list_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[2:0];
        got.read_value = m_tdata[66:3];
        got.element_count = m_tdata[71:67];
        got.is_empty = m_tdata[72];
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d value %h count %0d empty %0d",
                     got.status, got.read_value, got.element_count, got.is_empty);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result %0d: expected status %0d value %h count %0d empty %0d,",
                        " got status %0d value %h count %0d empty %0d"},
                       replies_seen, want.status, want.read_value, want.element_count,
                       want.is_empty, got.status, got.read_value, got.element_count,
                       got.is_empty);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && replies_seen >= 300) begin
        long_hold_done = 1'b1;
        stall_left = 80;
        m_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_element_bytes(input logic [iol_pkg::EB_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_bytes = v;
  endtask

  task automatic queue_op(input logic [iol_pkg::KIND_W-1:0] k,
                          input logic [iol_pkg::POS_W-1:0] p,
                          input logic [iol_pkg::DATA_W-1:0] d,
                          input logic [iol_pkg::SIZE_W-1:0] s);
    list_op_t op;
    op.kind = k;
    op.position = p;
    op.data_value = d;
    op.size_given = s;
    list_ops_q.push_back(op);
  endtask

  task automatic wait_list_idle();
    do @(negedge clk);
    while (list_ops_q.size() > 0 || s_tvalid || expected_replies.size() > 0);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [iol_pkg::EB_W-1:0]   phase_bytes[11];
    list_op_t                   op;
    int                         n;
    int                         run_len;
    int                         mode;
    int                         roll;
    logic [iol_pkg::DATA_W-1:0] d;
    phase_bytes = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd15, 4'd3, 4'd6, 4'd5, 4'd7, 4'd9, 4'd4};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_element_bytes(4'd4);
    @(negedge clk);
    queue_op(iol_pkg::KIND_POP, 0, '0, 4);
    queue_op(iol_pkg::KIND_FRONT, 0, '0, 4);
    queue_op(iol_pkg::KIND_FRONT, 0, '0, 3);
    queue_op(iol_pkg::KIND_BACK, 0, '0, 5);
    queue_op(iol_pkg::KIND_READ_AT, 0, '0, 4);
    queue_op(iol_pkg::KIND_READ_AT, 0, '0, 3);
    queue_op(iol_pkg::KIND_INSERT, 0, '1, 4);
    queue_op(iol_pkg::KIND_ERASE, 0, '0, 4);
    queue_op(iol_pkg::KIND_OVERWRITE, 0, '1, 4);
    queue_op(iol_pkg::KIND_PUSH, 0, '1, 5);
    queue_op(iol_pkg::KIND_PUSH, 0, '1, 4);
    queue_op(iol_pkg::KIND_PUSH, 15, '0, 4);
    queue_op(iol_pkg::KIND_PUSH, 0, 64'h5555_aaaa_5555_aaaa, 4);
    queue_op(iol_pkg::KIND_FRONT, 0, '0, 4);
    queue_op(iol_pkg::KIND_BACK, 0, '0, 4);
    queue_op(iol_pkg::KIND_READ_AT, 1, '0, 255);
    queue_op(iol_pkg::KIND_READ_AT, 3, '0, 4);
    queue_op(iol_pkg::KIND_INSERT, 0, 64'h0123_4567_89ab_cdef, 4);
    queue_op(iol_pkg::KIND_INSERT, 15, '1, 4);
    queue_op(iol_pkg::KIND_ERASE, 2, '0, 0);
    queue_op(iol_pkg::KIND_OVERWRITE, 1, 64'hfedc_ba98_7654_3210, 255);
    queue_op(iol_pkg::KIND_OVERWRITE, 1, '1, 3);
    queue_op(KIND_KIND_UNUSED_LOW, 0, '1, 4);
    queue_op({iol_pkg::KIND_W{1'b1}}, 15, '1, 255);
    queue_op(iol_pkg::KIND_CLEAR, 0, '0, 0);
    wait_list_idle();

    foreach (phase_bytes[ph]) begin
      write_element_bytes(phase_bytes[ph]);
      @(negedge clk);
      if (ph == $size(phase_bytes) - 1) idling_on = 1'b0;
      n = 0;
      while (n < 145) begin
        mode = $urandom_range(0, 2);
        run_len = $urandom_range(10, 30);
        for (int j = 0; j < run_len; j++) begin
          roll = $urandom_range(0, 99);
          case (mode)
            0: begin
              if (roll < 45) op.kind = iol_pkg::KIND_PUSH;
              else if (roll < 60) op.kind = iol_pkg::KIND_INSERT;
              else if (roll < 70) op.kind = iol_pkg::KIND_OVERWRITE;
              else if (roll < 77) op.kind = iol_pkg::KIND_FRONT;
              else if (roll < 84) op.kind = iol_pkg::KIND_BACK;
              else if (roll < 92) op.kind = iol_pkg::KIND_READ_AT;
              else if (roll < 96) op.kind = iol_pkg::KIND_POP;
              else op.kind = iol_pkg::KIND_ERASE;
            end
            1: begin
              if (roll < 30) op.kind = iol_pkg::KIND_POP;
              else if (roll < 55) op.kind = iol_pkg::KIND_ERASE;
              else if (roll < 75) op.kind = iol_pkg::KIND_READ_AT;
              else if (roll < 90) op.kind = iol_pkg::KIND_PUSH;
              else if (roll < 93) op.kind = iol_pkg::KIND_CLEAR;
              else op.kind = iol_pkg::KIND_OVERWRITE;
            end
            default: begin
              if (roll < 5)
                op.kind = 4'($urandom_range(KIND_KIND_UNUSED_LOW, {iol_pkg::KIND_W{1'b1}}));
              else
                op.kind = 4'($urandom_range(iol_pkg::KIND_PUSH, iol_pkg::KIND_CLEAR));
            end
          endcase
          roll = $urandom_range(0, 99);
          if (roll < 80) op.size_given = {4'd0, cfg_bytes};
          else if (roll < 88) op.size_given = {4'd0, cfg_bytes} + 8'd1;
          else if (roll < 94) op.size_given = {4'd0, cfg_bytes} - 8'd1;
          else op.size_given = 8'($urandom_range(0, 255));
          op.position = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(0, 3));
          roll = $urandom_range(0, 19);
          d = {$urandom, $urandom};
          if (roll == 0) d = '1;
          else if (roll == 1) d = '0;
          op.data_value = d;
          list_ops_q.push_back(op);
          n++;
        end
      end
      wait_list_idle();
    end

    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
